@@ sv/wpl_pkg.sv @@
package wpl_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxRadius = 2'd0,
    CfgZFloor    = 2'd1,
    CfgZCeiling  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } wpl_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     in_bounds;
  } wpl_out_t;

endpackage

@@ sv/wpl_sqrt.sv @@
module wpl_sqrt #(
  parameter int W = wpl_pkg::CoordW
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);

  logic [W+1:0]   rem_q  [0:W-1];
  logic [W-1:0]   root_q [0:W-1];
  logic [2*W-1:0] rad_q  [0:W-1];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+1:0]   rem_in, sh, trial, rem_d;
    logic [W-1:0]   root_in, root_d;
    logic [2*W-1:0] rad_in;
    logic           ge;

    always_comb begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
      end else begin
        rem_in  = rem_q[k == 0 ? 0 : k-1];
        root_in = root_q[k == 0 ? 0 : k-1];
        rad_in  = rad_q[k == 0 ? 0 : k-1];
      end
      sh     = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = (sh >= trial);
      rem_d  = ge ? (sh - trial) : sh;
      root_d = {root_in[W-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= {rad_in[2*W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[W-1];

endmodule

@@ sv/workspace_position_limiter.sv @@
// Throughput: one position per cycle; the whole pipeline advances unless a result is stalled.
// An input skid register takes one more transfer while the pipeline is held.
// Reset clears the valid bits, the skid flag and the configuration registers to zero.
module workspace_position_limiter #(
  parameter int FRAC_BITS = wpl_pkg::FracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wpl_pkg::wpl_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wpl_pkg::wpl_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wpl_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [wpl_pkg::CoordW-1:0]          cfg_data_i
);

  localparam int CW = wpl_pkg::CoordW;
  localparam int FB = FRAC_BITS;
  localparam int SW = CW + FB + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] zc;
    logic                 ok;
    logic                 rpos;
  } side_t;

  logic [CW-2:0]        max_radius_q;
  logic signed [CW-1:0] z_floor_q, z_ceiling_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_radius_q <= '0;
      z_floor_q    <= '0;
      z_ceiling_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (wpl_pkg::cfg_idx_e'(cfg_index_i))
        wpl_pkg::CfgMaxRadius: max_radius_q <= cfg_data_i[CW-2:0];
        wpl_pkg::CfgZFloor:    z_floor_q    <= cfg_data_i;
        wpl_pkg::CfgZCeiling:  z_ceiling_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             adv, in_take, skid_vld_q, vo_q;
  wpl_pkg::wpl_in_t skid_q, src;

  assign adv        = !vo_q || !out_stall_i;
  assign in_stall_o = skid_vld_q;
  assign in_take    = in_valid_i && !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      skid_vld_q <= 1'b0;
    end else if (in_take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_take) skid_q <= in_data_i;
  end

  assign src = skid_vld_q ? skid_q : in_data_i;

  // clamp z to the band and radius
  logic signed [CW:0] lo, hi, rs, zs, zcl;
  logic               band, rpos;
  side_t              s1_d;

  always_comb begin
    rs   = $signed({2'b00, max_radius_q});
    rpos = (max_radius_q != '0);
    band = (z_floor_q < z_ceiling_q);
    if (band) begin
      lo = $signed({z_floor_q[CW-1], z_floor_q});
      hi = $signed({z_ceiling_q[CW-1], z_ceiling_q});
    end else begin
      lo = $signed({2'b11, {(CW-1){1'b0}}});
      hi = $signed({2'b00, {(CW-1){1'b1}}});
    end
    if (rpos) begin
      if (lo < -rs) lo = -rs;
      if (hi > rs) hi = rs;
    end
    zs = $signed({src.pos_z[CW-1], src.pos_z});
    if (zs < lo) zcl = lo;
    else if (zs > hi) zcl = hi;
    else zcl = zs;
    s1_d.x    = src.pos_x;
    s1_d.y    = src.pos_y;
    s1_d.z    = src.pos_z;
    s1_d.zc   = zcl[CW-1:0];
    s1_d.ok   = (lo <= hi);
    s1_d.rpos = rpos;
  end

  side_t         s1_q, s2_q, s3_q;
  logic          v1_q, v2_q, v3_q;
  logic [CW-1:0] ax1, ay1, az1;
  logic [2*CW-1:0] xx_q, yy_q, rr_q, zz_q, hs_q, ms_q;

  assign ax1 = s1_q.x[CW-1] ? CW'(-s1_q.x) : CW'(s1_q.x);
  assign ay1 = s1_q.y[CW-1] ? CW'(-s1_q.y) : CW'(s1_q.y);
  assign az1 = s1_q.zc[CW-1] ? CW'(-s1_q.zc) : CW'(s1_q.zc);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      xx_q <= (2*CW)'(ax1) * (2*CW)'(ax1);
      yy_q <= (2*CW)'(ay1) * (2*CW)'(ay1);
      zz_q <= (2*CW)'(az1) * (2*CW)'(az1);
      rr_q <= (2*CW)'(max_radius_q) * (2*CW)'(max_radius_q);
      s3_q <= s2_q;
      hs_q <= xx_q + yy_q;
      ms_q <= rr_q - zz_q;
    end
  end

  logic [CW-1:0] h_root, m_root;

  wpl_sqrt #(.W(CW)) u_sqrt_h (.clk_i(clk_i), .en_i(adv), .rad_i(hs_q), .root_o(h_root));
  wpl_sqrt #(.W(CW)) u_sqrt_m (.clk_i(clk_i), .en_i(adv), .rad_i(ms_q), .root_o(m_root));

  side_t sd_q [0:CW-1];
  logic  sv_q [0:CW-1];

  for (genvar k = 0; k < CW; k++) begin : g_sq_side
    always_ff @(posedge clk_i) begin
      if (adv) sd_q[k] <= (k == 0) ? s3_q : sd_q[k == 0 ? 0 : k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k] <= 1'b0;
      else if (adv) sv_q[k] <= (k == 0) ? v3_q : sv_q[k == 0 ? 0 : k-1];
    end
  end

  // restoring divide of m * 2^FRAC_BITS by h, one quotient bit a stage
  side_t         ds_q  [0:FB];
  logic          dsc_q [0:FB];
  logic          dv_q  [0:FB];
  logic [CW-1:0] dh_q  [0:FB];
  logic [CW-1:0] drem_q[0:FB];
  logic [FB:0]   dq_q  [0:FB];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_q[0]   <= sd_q[CW-1];
      dsc_q[0]  <= sd_q[CW-1].ok && sd_q[CW-1].rpos && (h_root > m_root);
      dh_q[0]   <= h_root;
      drem_q[0] <= m_root;
      dq_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_div
    logic [CW:0] rem2, hh, rem_n;
    logic        ge;
    always_comb begin
      rem2  = {drem_q[k-1], 1'b0};
      hh    = {1'b0, dh_q[k-1]};
      ge    = (rem2 >= hh);
      rem_n = ge ? (rem2 - hh) : rem2;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ds_q[k]   <= ds_q[k-1];
        dsc_q[k]  <= dsc_q[k-1];
        dh_q[k]   <= dh_q[k-1];
        drem_q[k] <= rem_n[CW-1:0];
        dq_q[k]   <= {dq_q[k-1][FB-1:0], ge};
      end
    end
  end

  for (genvar k = 0; k <= FB; k++) begin : g_div_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else if (adv) dv_q[k] <= (k == 0) ? sv_q[CW-1] : dv_q[k == 0 ? 0 : k-1];
    end
  end

  side_t         ms_side_q;
  logic          msc_q, vm_q;
  logic [SW-1:0] px_q, py_q;
  logic [CW-1:0] axd, ayd;

  assign axd = ds_q[FB].x[CW-1] ? CW'(-ds_q[FB].x) : CW'(ds_q[FB].x);
  assign ayd = ds_q[FB].y[CW-1] ? CW'(-ds_q[FB].y) : CW'(ds_q[FB].y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ms_side_q <= ds_q[FB];
      msc_q     <= dsc_q[FB];
      px_q      <= SW'(axd) * SW'(dq_q[FB]);
      py_q      <= SW'(ayd) * SW'(dq_q[FB]);
    end
  end

  logic [CW-1:0]     mgx, mgy;
  wpl_pkg::wpl_out_t out_d, out_q;

  always_comb begin
    mgx = px_q[FB +: CW];
    mgy = py_q[FB +: CW];
    out_d.in_bounds = ms_side_q.ok;
    if (!ms_side_q.ok) begin
      out_d.out_x = ms_side_q.x;
      out_d.out_y = ms_side_q.y;
      out_d.out_z = ms_side_q.z;
    end else begin
      out_d.out_z = ms_side_q.zc;
      if (msc_q) begin
        out_d.out_x = ms_side_q.x[CW-1] ? -$signed(mgx) : $signed(mgx);
        out_d.out_y = ms_side_q.y[CW-1] ? -$signed(mgy) : $signed(mgy);
      end else begin
        out_d.out_x = ms_side_q.x;
        out_d.out_y = ms_side_q.y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= skid_vld_q || in_take;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vm_q <= dv_q[FB];
      vo_q <= vm_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && out_stall_i) |=> vo_q) else $error("result dropped while stalled");
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !adv) |=> skid_vld_q) else $error("skid entry lost");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> !skid_vld_q) else $error("skid not drained on advance");

endmodule
